// ===== hdl/pdid_pkg.sv =====
`default_nettype none

package pdid_pkg;

    // Pin modes
    localparam logic [1:0] PIN_IN   = 2'd0;
    localparam logic [1:0] PIN_LOW  = 2'd1;
    localparam logic [1:0] PIN_HIGH = 2'd2;
    localparam logic [1:0] PIN_ALT  = 2'd3;

    // ID1 classes
    localparam logic [1:0] CLS_GND  = 2'd0;
    localparam logic [1:0] CLS_VCC  = 2'd1;
    localparam logic [1:0] CLS_PULL = 2'd2;
    localparam logic [1:0] CLS_OPEN = 2'd3;

    // Device type codes
    localparam logic [3:0] T_NONE   = 4'd0;
    localparam logic [3:0] T_TOUCH  = 4'd5;
    localparam logic [3:0] T_TPOINT = 4'd11;
    localparam logic [3:0] T_EXPLOD = 4'd12;
    localparam logic [3:0] T_3PART  = 4'd13;
    localparam logic [3:0] T_UART   = 4'd14;

    localparam logic [7:0] THRESHOLD_RESET = 8'd20;
    localparam logic [7:0] COUNT_MAX       = 8'd255;

    typedef enum logic [11:0] {
        STEP_0  = 12'b0000_0000_0001,
        STEP_1  = 12'b0000_0000_0010,
        STEP_2  = 12'b0000_0000_0100,
        STEP_3  = 12'b0000_0000_1000,
        STEP_4  = 12'b0000_0001_0000,
        STEP_5  = 12'b0000_0010_0000,
        STEP_6  = 12'b0000_0100_0000,
        STEP_7  = 12'b0000_1000_0000,
        STEP_8  = 12'b0001_0000_0000,
        STEP_9  = 12'b0010_0000_0000,
        STEP_10 = 12'b0100_0000_0000,
        STEP_11 = 12'b1000_0000_0000
    } probe_step_t;

    typedef struct packed {
        probe_step_t step;
        logic [1:0]  cls;
        logic [3:0]  cand;
        logic [3:0]  last;
        logic        saved;
        logic [7:0]  count;
        logic [3:0]  accepted;
        logic [3:0]  reported;
        logic [1:0]  id1_pin;
        logic [1:0]  buffer_pin;
        logic [1:0]  id2_pin;
    } port_state_t;

    localparam port_state_t PORT_STATE_RESET = '{
        step:       STEP_0,
        cls:        CLS_GND,
        cand:       T_NONE,
        last:       T_NONE,
        saved:      1'b0,
        count:      8'd0,
        accepted:   T_NONE,
        reported:   T_NONE,
        id1_pin:    PIN_IN,
        buffer_pin: PIN_IN,
        id2_pin:    PIN_IN
    };

    // Type by ID1 class (ground, vcc, pull-down) and ID2/RX response column
    function automatic logic [3:0] type_lookup(input logic [1:0] cls, input logic [1:0] col);
        logic [3:0] t;
        t = T_NONE;
        case (cls)
            CLS_GND: begin
                case (col)
                    2'd0:    t = 4'd4;
                    2'd1:    t = 4'd3;
                    default: t = 4'd10;
                endcase
            end
            CLS_VCC: begin
                case (col)
                    2'd0:    t = 4'd2;
                    2'd1:    t = 4'd6;
                    default: t = 4'd9;
                endcase
            end
            default: begin
                case (col)
                    2'd0:    t = 4'd1;
                    2'd1:    t = 4'd7;
                    default: t = 4'd8;
                endcase
            end
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/pdid_probe_core.sv =====
`default_nettype none

module pdid_probe_core
    import pdid_pkg::*;
(
    input  port_state_t cur_state,
    input  logic        id1_level,
    input  logic        id2_level,
    input  logic        rx_level,
    input  logic [7:0]  threshold,
    output port_state_t next_state,
    output logic        changed
);

    logic [7:0] count_inc;

    assign count_inc = (cur_state.count < COUNT_MAX) ? cur_state.count + 8'd1 : COUNT_MAX;

    always_comb begin
        next_state = cur_state;
        changed    = 1'b0;

        // once in UART mode the port is no longer probed
        if (cur_state.accepted != T_UART) begin
            unique case (cur_state.step)
                STEP_0: begin
                    next_state.cand       = T_NONE;
                    next_state.cls        = CLS_OPEN;
                    next_state.id1_pin    = PIN_HIGH;
                    next_state.buffer_pin = PIN_LOW;
                    next_state.id2_pin    = PIN_IN;
                    next_state.step       = STEP_1;
                end
                STEP_1: begin
                    next_state.saved   = id2_level;
                    next_state.id2_pin = PIN_IN;
                    next_state.id1_pin = PIN_LOW;
                    next_state.step    = STEP_2;
                end
                STEP_2: begin
                    next_state.id2_pin = PIN_IN;
                    if (cur_state.saved && !id2_level) begin
                        next_state.cand       = T_TOUCH;
                        next_state.buffer_pin = PIN_HIGH;
                        next_state.id1_pin    = PIN_IN;
                        next_state.step       = STEP_3;
                    end else if (!cur_state.saved && id2_level) begin
                        next_state.cand = T_TPOINT;
                        next_state.step = STEP_11;
                    end else begin
                        next_state.saved   = id1_level;
                        next_state.id1_pin = PIN_HIGH;
                        next_state.step    = STEP_4;
                    end
                end
                STEP_3: begin
                    next_state.step = STEP_11;
                end
                STEP_4: begin
                    if (cur_state.saved && id1_level) begin
                        next_state.cls  = CLS_VCC;
                        next_state.step = STEP_6;
                    end else if (!cur_state.saved && !id1_level) begin
                        next_state.cls  = CLS_GND;
                        next_state.step = STEP_6;
                    end else begin
                        next_state.buffer_pin = PIN_HIGH;
                        next_state.id1_pin    = PIN_IN;
                        next_state.step       = STEP_5;
                    end
                end
                STEP_5: begin
                    next_state.cls  = id1_level ? CLS_OPEN : CLS_PULL;
                    next_state.step = STEP_6;
                end
                STEP_6: begin
                    next_state.buffer_pin = PIN_HIGH;
                    next_state.id1_pin    = PIN_IN;
                    next_state.id2_pin    = PIN_HIGH;
                    next_state.step       = STEP_7;
                end
                STEP_7: begin
                    next_state.saved   = id1_level;
                    next_state.id2_pin = PIN_LOW;
                    next_state.step    = STEP_8;
                end
                STEP_8: begin
                    if (cur_state.saved && !id1_level) begin
                        if (cur_state.cls == CLS_OPEN) begin
                            next_state.cand = T_3PART;
                        end
                        next_state.step = STEP_11;
                    end else if (!cur_state.saved && id1_level) begin
                        next_state.cand = T_EXPLOD;
                        next_state.step = STEP_11;
                    end else begin
                        next_state.id1_pin    = PIN_HIGH;
                        next_state.buffer_pin = PIN_LOW;
                        next_state.id2_pin    = PIN_HIGH;
                        next_state.step       = STEP_9;
                    end
                end
                STEP_9: begin
                    if (rx_level) begin
                        next_state.id2_pin = PIN_LOW;
                        next_state.step    = STEP_10;
                    end else begin
                        next_state.cand = (cur_state.cls != CLS_OPEN) ?
                                          type_lookup(cur_state.cls, 2'd0) : T_UART;
                        next_state.step = STEP_11;
                    end
                end
                STEP_10: begin
                    if (cur_state.cls != CLS_OPEN) begin
                        next_state.cand = type_lookup(cur_state.cls,
                                                      rx_level ? 2'd1 : 2'd2);
                    end
                    next_state.step = STEP_11;
                end
                STEP_11: begin
                    next_state.id2_pin    = PIN_IN;
                    next_state.id1_pin    = PIN_LOW;
                    next_state.buffer_pin = PIN_LOW;
                    // counter only advances on a repeat; a mismatch leaves it alone
                    if (cur_state.cand == cur_state.last) begin
                        if (count_inc >= threshold) begin
                            next_state.accepted = cur_state.cand;
                            next_state.count    = count_inc - 8'd1;
                        end else begin
                            next_state.count = count_inc;
                        end
                    end
                    next_state.last = cur_state.cand;
                    next_state.step = STEP_0;
                end
                default: begin
                    next_state.step = STEP_0;
                end
            endcase
        end

        if (next_state.accepted != cur_state.reported) begin
            next_state.reported = next_state.accepted;
            changed             = 1'b1;
            if (next_state.accepted == T_UART) begin
                next_state.id2_pin    = PIN_ALT;
                next_state.id1_pin    = PIN_ALT;
                next_state.buffer_pin = PIN_LOW;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/pdid_state_bank.sv =====
`default_nettype none

module pdid_state_bank
    import pdid_pkg::*;
#(
    parameter int NUM_PORTS = 2,
    parameter int IDX_W     = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [IDX_W-1:0]  port_idx,
    input  logic              wr_en,
    input  port_state_t       wr_state,
    output port_state_t       rd_state
);

    port_state_t state_reg [NUM_PORTS];

    assign rd_state = state_reg[port_idx];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_PORTS; i++) begin
                state_reg[i] <= PORT_STATE_RESET;
            end
        end else if (wr_en) begin
            state_reg[port_idx] <= wr_state;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/port_device_id_probe_unit.sv =====
`default_nettype none

// Passive device ID probe for up to NUM_PORTS ports.
// Input channel (s_*): one transfer per 2 ms tick of one port, with the
// sampled ID1, ID2 and RX levels. Result channel (m_*): exactly one transfer
// per input transfer, in order, carrying the pin drive modes after the tick,
// the candidate and connected type codes, a change flag and the UART flag.
// A tick for a port number at or above NUM_PORTS leaves all state alone and
// returns an all-zero result.
// The input register feeds the probe step logic, which loads the per-port
// state registers and the result register together once the result
// register is free. One transfer per cycle is sustained while the receiver
// does not stall, also for back-to-back ticks of the same port.
// cfg_wr_en writes match_threshold (reset 20) at once; write it only idle.
// Reset (aresetn low, synchronous) puts every port at probe step 0 with all
// pins as inputs, no types, counters zero, and empties both registers.
// When the receiver stalls, the result register holds; the input register
// takes one more transfer and then s_ready drops until the result moves.
module port_device_id_probe_unit
    import pdid_pkg::*;
#(
    parameter int NUM_PORTS = 2
) (
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_port_select,
    input  logic       s_id1_level,
    input  logic       s_id2_level,
    input  logic       s_rx_level,

    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_id1_drive,
    output logic [1:0] m_buffer_drive,
    output logic [1:0] m_id2_drive,
    output logic [3:0] m_detected_type,
    output logic [3:0] m_connected_type,
    output logic       m_connection_changed,
    output logic       m_uart_mode
);

    localparam int IDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

    logic [7:0]  threshold_reg;

    logic        in_valid_reg;
    logic        sel_reg;
    logic        id1_reg;
    logic        id2_reg;
    logic        rx_reg;

    logic        m_valid_reg;
    logic [1:0]  id1_drive_reg;
    logic [1:0]  buffer_drive_reg;
    logic [1:0]  id2_drive_reg;
    logic [3:0]  detected_reg;
    logic [3:0]  connected_reg;
    logic        changed_reg;
    logic        uart_reg;

    logic             advance;
    logic             in_range;
    logic [IDX_W-1:0] port_idx;
    port_state_t      cur_state;
    port_state_t      nxt_state;
    logic             changed;

    assign advance  = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;
    // port_select is one bit wide, so only port 1 can fall outside the range
    assign in_range = (NUM_PORTS > 1) || !sel_reg;
    assign port_idx = IDX_W'(sel_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= THRESHOLD_RESET;
        end else if (cfg_wr_en) begin
            threshold_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            sel_reg <= s_port_select;
            id1_reg <= s_id1_level;
            id2_reg <= s_id2_level;
            rx_reg  <= s_rx_level;
        end
    end

    pdid_state_bank #(
        .NUM_PORTS (NUM_PORTS),
        .IDX_W     (IDX_W)
    ) u_state_bank (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .port_idx (port_idx),
        .wr_en    (advance && in_range),
        .wr_state (nxt_state),
        .rd_state (cur_state)
    );

    pdid_probe_core u_probe_core (
        .cur_state  (cur_state),
        .id1_level  (id1_reg),
        .id2_level  (id2_reg),
        .rx_level   (rx_reg),
        .threshold  (threshold_reg),
        .next_state (nxt_state),
        .changed    (changed)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            if (in_range) begin
                id1_drive_reg    <= nxt_state.id1_pin;
                buffer_drive_reg <= nxt_state.buffer_pin;
                id2_drive_reg    <= nxt_state.id2_pin;
                detected_reg     <= nxt_state.cand;
                connected_reg    <= nxt_state.accepted;
                changed_reg      <= changed;
                uart_reg         <= (nxt_state.accepted == T_UART);
            end else begin
                id1_drive_reg    <= PIN_IN;
                buffer_drive_reg <= PIN_IN;
                id2_drive_reg    <= PIN_IN;
                detected_reg     <= T_NONE;
                connected_reg    <= T_NONE;
                changed_reg      <= 1'b0;
                uart_reg         <= 1'b0;
            end
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_id1_drive          = id1_drive_reg;
    assign m_buffer_drive       = buffer_drive_reg;
    assign m_id2_drive          = id2_drive_reg;
    assign m_detected_type      = detected_reg;
    assign m_connected_type     = connected_reg;
    assign m_connection_changed = changed_reg;
    assign m_uart_mode          = uart_reg;

endmodule

`default_nettype wire
